/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and micro-op codes of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] req_size;
        logic [15:0] release_offset;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [15:0] grant_offset;
    } t_out_word;

    // one block header as held in the store
    typedef struct packed {
        logic        valid;
        logic        free;
        logic [15:0] size;
        logic [15:0] prev;
        logic [15:0] next;
    } t_hdr;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLR,
        OP_A_CHK,
        OP_A_W2,
        OP_A_WF,
        OP_A_W3,
        OP_F_HD,
        OP_F_NX,
        OP_F_NXI,
        OP_F_NXP,
        OP_F_PV,
        OP_F_PVC,
        OP_F_PVI,
        OP_F_PVP,
        OP_RES
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic fit;
        logic split;
        logic last;
        logic bad;
        logic rd_next_nz;
        logic rd_free;
        logic cur_next_nz;
        logic b_next_nz;
        logic a_next_nz;
        logic hdr_zero;
    } t_stat;

endpackage

/* rtl/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer: steps the datapath through clear, walk, split and coalesce
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_func,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ACHK, S_AW2, S_AWF, S_AW3,
        S_FHD, S_FNX, S_FNXI, S_FNXP, S_FPV, S_FPVC, S_FPVI, S_FPVP, S_RES
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: if (accept) n_state = (i_func == FUNC_FREE) ? S_FHD : S_ACHK;
            S_ACHK: begin
                if (i_stat.fit) n_state = i_stat.split ? S_AW2 : S_AWF;
                else if (i_stat.last) n_state = S_RES;
            end
            S_AW2:  n_state = i_stat.cur_next_nz ? S_AW3 : S_RES;
            S_AWF:  n_state = S_RES;
            S_AW3:  n_state = S_RES;
            S_FHD: begin
                if (i_stat.bad) n_state = S_RES;
                else n_state = i_stat.rd_next_nz ? S_FNX : S_FPV;
            end
            S_FNX:  n_state = i_stat.rd_free ? S_FNXI : S_FPV;
            S_FNXI: n_state = i_stat.b_next_nz ? S_FNXP : S_FPV;
            S_FNXP: n_state = S_FPV;
            S_FPV:  n_state = i_stat.hdr_zero ? S_RES : S_FPVC;
            S_FPVC: n_state = i_stat.rd_free ? S_FPVI : S_RES;
            S_FPVI: n_state = i_stat.a_next_nz ? S_FPVP : S_RES;
            S_FPVP: n_state = S_RES;
            S_RES:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    always_comb begin
        o_cmd.accept = accept;
        case (r_state)
            S_CLR:   o_cmd.op = OP_CLR;
            S_ACHK:  o_cmd.op = OP_A_CHK;
            S_AW2:   o_cmd.op = OP_A_W2;
            S_AWF:   o_cmd.op = OP_A_WF;
            S_AW3:   o_cmd.op = OP_A_W3;
            S_FHD:   o_cmd.op = OP_F_HD;
            S_FNX:   o_cmd.op = OP_F_NX;
            S_FNXI:  o_cmd.op = OP_F_NXI;
            S_FNXP:  o_cmd.op = OP_F_NXP;
            S_FPV:   o_cmd.op = OP_F_PV;
            S_FPVC:  o_cmd.op = OP_F_PVC;
            S_FPVI:  o_cmd.op = OP_F_PVI;
            S_FPVP:  o_cmd.op = OP_F_PVP;
            S_RES:   o_cmd.op = OP_RES;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_busy = r_busy;

endmodule

/* rtl/ffha_datapath.sv */
// ----------------------------------------------------------------------------
// ffha_datapath
// header store, walk registers and result register
// ----------------------------------------------------------------------------
module ffha_datapath #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffha_pkg::t_cmd      i_cmd,
    input  ffha_pkg::t_in_word  i_word,
    output ffha_pkg::t_stat     o_stat,
    output logic                o_strobe,
    output ffha_pkg::t_out_word o_word
);
    import ffha_pkg::*;

    localparam int          CW       = $clog2(HEAP_BYTES + 1);
    localparam logic [15:0] HDR      = 16'(HEADER_BYTES);
    localparam logic [17:0] HDR2     = 18'(2 * HEADER_BYTES);
    localparam logic [15:0] INIT_SZ  = 16'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW:0] LIMIT    = (CW + 1)'(HEAP_BYTES);

    t_hdr mem [65536];
    t_hdr r_rd;

    t_in_word    r_word;
    logic [15:0] r_off, r_noff, r_hdr, r_nxt, r_clr;
    logic [CW-1:0] r_cnt;
    logic        r_fail, r_small, r_strobe;
    t_hdr        r_cur, r_a, r_b;
    t_out_word   r_out;

    logic        rd_en, wr_en;
    logic [15:0] rd_addr, wr_addr;
    t_hdr        wr_data;
    t_hdr        cur, init_e, merged_n, merged_p, cur_freed;
    logic        fit, split, last;
    logic [15:0] noff;

    assign cur   = r_rd;
    assign fit   = cur.free && (cur.size >= r_word.req_size);
    assign split = {2'b00, cur.size} > ({2'b00, r_word.req_size} + HDR2);
    assign noff  = r_off + r_word.req_size + HDR;
    assign last  = (cur.next == 16'd0) || (({1'b0, r_cnt} + 1'b1) == LIMIT);

    always_comb begin
        init_e       = '0;
        init_e.valid = 1'b1;
        init_e.free  = 1'b1;
        init_e.size  = INIT_SZ;
        cur_freed      = cur;
        cur_freed.free = 1'b1;
        merged_n      = r_a;
        merged_n.size = r_a.size + HDR + cur.size;
        merged_n.next = cur.next;
        merged_p      = cur;
        merged_p.size = cur.size + HDR + r_a.size;
        merged_p.next = r_a.next;
    end

    // memory access decode
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.accept) begin
            rd_en   = 1'b1;
            rd_addr = (i_word.func == FUNC_FREE) ? (i_word.release_offset - HDR) : 16'd0;
        end
        case (i_cmd.op)
            OP_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == 16'd0) ? init_e : '0;
            end
            OP_A_CHK: begin
                if (fit && split) begin
                    wr_en   = 1'b1;
                    wr_addr = noff;
                    wr_data = '{valid: 1'b1, free: 1'b1,
                                size: 16'(cur.size - r_word.req_size - HDR),
                                prev: r_off, next: cur.next};
                end else if (!fit && !last) begin
                    rd_en   = 1'b1;
                    rd_addr = cur.next;
                end
            end
            OP_A_W2: begin
                wr_en   = 1'b1;
                wr_addr = r_off;
                wr_data = '{valid: 1'b1, free: 1'b0, size: r_word.req_size,
                            prev: r_cur.prev, next: r_noff};
                rd_en   = (r_cur.next != 16'd0);
                rd_addr = r_cur.next;
            end
            OP_A_WF: begin
                wr_en        = 1'b1;
                wr_addr      = r_off;
                wr_data      = r_cur;
                wr_data.free = 1'b0;
            end
            OP_A_W3: begin
                wr_en        = 1'b1;
                wr_addr      = r_cur.next;
                wr_data      = r_rd;
                wr_data.prev = r_noff;
            end
            OP_F_HD: begin
                if (!o_stat.bad) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_hdr;
                    wr_data      = cur;
                    wr_data.free = 1'b1;
                    rd_en        = (cur.next != 16'd0);
                    rd_addr      = cur.next;
                end
            end
            OP_F_NX: begin
                if (cur.free) begin
                    wr_en   = 1'b1;
                    wr_addr = r_hdr;
                    wr_data = merged_n;
                end
            end
            OP_F_NXI: begin
                wr_en         = 1'b1;
                wr_addr       = r_nxt;
                wr_data       = r_b;
                wr_data.valid = 1'b0;
                rd_en         = (r_b.next != 16'd0);
                rd_addr       = r_b.next;
            end
            OP_F_NXP: begin
                wr_en        = 1'b1;
                wr_addr      = r_b.next;
                wr_data      = r_rd;
                wr_data.prev = r_hdr;
            end
            OP_F_PV: begin
                rd_en   = 1'b1;
                rd_addr = r_a.prev;
            end
            OP_F_PVC: begin
                if (cur.free) begin
                    wr_en   = 1'b1;
                    wr_addr = r_a.prev;
                    wr_data = merged_p;
                end
            end
            OP_F_PVI: begin
                wr_en         = 1'b1;
                wr_addr       = r_hdr;
                wr_data       = r_a;
                wr_data.valid = 1'b0;
                rd_en         = (r_a.next != 16'd0);
                rd_addr       = r_a.next;
            end
            OP_F_PVP: begin
                wr_en        = 1'b1;
                wr_addr      = r_a.next;
                wr_data      = r_rd;
                wr_data.prev = r_a.prev;
            end
            default: begin
            end
        endcase
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLR) r_clr <= r_clr + 16'd1;
            r_strobe <= (i_cmd.op == OP_RES);
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_word  <= i_word;
            r_off   <= '0;
            r_cnt   <= '0;
            r_fail  <= 1'b0;
            r_hdr   <= i_word.release_offset - HDR;
            r_small <= (i_word.release_offset < HDR);
        end
        case (i_cmd.op)
            OP_A_CHK: begin
                r_cur  <= cur;
                r_noff <= noff;
                r_cnt  <= r_cnt + 1'b1;
                if (!fit) begin
                    if (last) r_fail <= 1'b1;
                    else r_off <= cur.next;
                end
            end
            OP_F_HD: begin
                r_a   <= cur_freed;
                r_nxt <= cur.next;
            end
            OP_F_NX: begin
                r_b <= cur;
                if (cur.free) r_a <= merged_n;
            end
            OP_RES: begin
                r_out.status       <= r_fail;
                r_out.grant_offset <= (r_word.func == FUNC_FREE || r_fail) ? 16'd0
                                                                           : r_off + HDR;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.clr_last    = (r_clr == 16'hFFFF);
        o_stat.fit         = fit;
        o_stat.split       = split;
        o_stat.last        = last;
        o_stat.bad         = r_small || !cur.valid || cur.free;
        o_stat.rd_next_nz  = (cur.next != 16'd0);
        o_stat.rd_free     = cur.free;
        o_stat.cur_next_nz = (r_cur.next != 16'd0);
        o_stat.b_next_nz   = (r_b.next != 16'd0);
        o_stat.a_next_nz   = (r_a.next != 16'd0);
        o_stat.hdr_zero    = (r_hdr == 16'd0);
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

endmodule

/* rtl/first_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// first-fit heap allocator with block splitting and free coalescing
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-entry header store, one entry a
// cycle, so busy stays high for the whole clear pass before a word is taken.
// A word is taken when start is high and busy is low; exactly one result word
// follows on o_word, marked by a one-cycle o_strobe that cannot be held off.
// An allocate walks the header chain from offset 0 at one header per store
// read. It ends in a failure at the last header, in a grant of a whole free
// block, or in a split that writes the new free header and the granted one
// and, when the split block has a successor, updates that successor's prev
// link. A free marks the block free and merges it with whichever of its next
// and previous neighbors are free. The single read port of the header store
// paces these steps. A new word may be given in the same cycle as the strobe.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ffha_pkg::t_in_word  i_word,
    output logic                o_busy,
    output logic                o_strobe,
    output ffha_pkg::t_out_word o_word
);
    import ffha_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear pass, chain walk, split and coalesce steps
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_word.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // header store and walk registers
    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_word   (i_word),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

endmodule

/* rtl/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_checker
// port-level checks of the heap allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_strobe,
    input ffha_pkg::t_out_word o_word
);
    // one result word per request, never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // a taken word keeps the unit busy and gives no result in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_strobe))
        else $error("unit not busy after taking a word");

    // a failed allocate grants nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.status) |-> (o_word.grant_offset == 16'd0))
        else $error("no-fit result with nonzero offset");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);
